>>> src/ssd_pkg.sv
`timescale 1ns / 1ps
package ssd_pkg;

  // Coordinate bits taken from each input field, 8..32
  localparam int COORD_W = 32;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 51;
  localparam int FRAC_W  = 16;

  // Derived widths
  localparam int DW     = COORD_W + 1;              // coordinate difference
  localparam int PRODW  = 2 * DW;                   // difference product
  localparam int DOTW   = 2 * DW + 1;               // dot product
  localparam int MDW    = DOTW + 2;                 // -d and b - d
  localparam int QW     = FRAC_W + 1;               // segment parameter, 0..1
  localparam int DXW    = DW + FRAC_W + 2;          // closest-point difference
  localparam int MW     = (DOTW > DXW) ? DOTW : DXW; // wide multiplier operand
  localparam int ML     = (MW + 1) / 2;
  localparam int MH     = MW - ML;
  localparam int PW     = 2 * MW;
  localparam int NW     = PW + 1;                   // determinant and numerators
  localparam int RW     = NW + FRAC_W;              // divider remainder
  localparam int DROP_W = 3 * FRAC_W;
  localparam int SATW   = OUT_W + DROP_W;
  localparam int NXW    = (NW > SATW) ? NW : SATW + 1;
  localparam int QONE   = 1 << FRAC_W;

  // Pipeline stage numbers
  localparam int DIV_STG = FRAC_W + 1;
  localparam int ST_DIFF = 1;
  localparam int ST_PROD = 2;
  localparam int ST_DOT  = 3;
  localparam int ST_MUL  = 4;                       // two stages
  localparam int ST_DET  = 6;
  localparam int ST_CL1  = 7;
  localparam int ST_CL2  = 8;
  localparam int ST_DIV0 = 9;
  localparam int ST_DIVN = ST_DIV0 + DIV_STG - 1;
  localparam int ST_SCL  = ST_DIVN + 1;
  localparam int ST_DX   = ST_SCL + 1;
  localparam int ST_SQ   = ST_DX + 1;               // two stages
  localparam int NSTG    = ST_SQ + 2;

  typedef struct packed {
    logic signed [DW-1:0] ux;
    logic signed [DW-1:0] uy;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] wy;
  } geo_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
  } dot_t;

  typedef struct packed {
    logic signed [NW-1:0] sn;
    logic signed [NW-1:0] sd;
    logic signed [NW-1:0] tn;
    logic signed [NW-1:0] td;
  } frac_t;

endpackage

>>> src/ssd_mul.sv
`timescale 1ns / 1ps
// Two-stage signed multiplier: four partial products, then one merge add.
module ssd_mul (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [ssd_pkg::MW-1:0] a,
  input  logic signed [ssd_pkg::MW-1:0] b,
  output logic signed [ssd_pkg::PW-1:0] p
);
  import ssd_pkg::*;

  logic        [ML-1:0]    al, bl;
  logic signed [MH-1:0]    ah, bh;
  logic        [2*ML-1:0]  pll_nxt, pll_r;
  logic signed [MH+ML:0]   phl_nxt, plh_nxt, phl_r, plh_r;
  logic signed [2*MH-1:0]  phh_nxt, phh_r;
  logic signed [PW-1:0]    p_nxt, p_r;

  assign al = a[ML-1:0];
  assign bl = b[ML-1:0];
  assign ah = a[MW-1:ML];
  assign bh = b[MW-1:ML];

  assign pll_nxt = al * bl;
  assign phl_nxt = ah * $signed({1'b0, bl});
  assign plh_nxt = $signed({1'b0, al}) * bh;
  assign phh_nxt = ah * bh;

  // high x high and low x low occupy disjoint bits
  assign p_nxt = $signed({phh_r, pll_r}) + ((PW'(phl_r) + PW'(plh_r)) <<< ML);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pll_r <= pll_nxt;
      phl_r <= phl_nxt;
      plh_r <= plh_nxt;
      phh_r <= phh_nxt;
    end
    if (en[1]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

>>> src/ssd_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: trunc(num * 2^FRAC_W / den), one quotient bit per stage.
// Non-positive numerator or divisor gives zero.
module ssd_div (
  input  logic                              clk,
  input  logic [ssd_pkg::DIV_STG-1:0]       en,
  input  logic signed [ssd_pkg::NW-1:0]     num,
  input  logic signed [ssd_pkg::NW-1:0]     den,
  output logic        [ssd_pkg::QW-1:0]     quo
);
  import ssd_pkg::*;

  logic [RW-1:0] rem_r [DIV_STG-1];
  logic [RW-1:0] dvs_r [DIV_STG-1];
  logic [QW-1:0] quo_r [DIV_STG];
  logic          ok;
  logic [RW-1:0] rem0, dvs0;

  assign ok   = (num > 0) && (den > 0);
  assign rem0 = ok ? (RW'(num[NW-2:0]) << FRAC_W) : '0;
  assign dvs0 = ok ? RW'(den[NW-2:0]) : RW'(1);

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
    localparam int K = FRAC_W - j;
    logic [RW-1:0] rem_in, dvs_in, shf;
    logic [QW-1:0] quo_in;
    logic          fit;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign dvs_in = dvs0;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign dvs_in = dvs_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign shf = dvs_in << K;
    assign fit = rem_in >= shf;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        quo_r[j] <= quo_in | (QW'(fit) << K);
      end
    end

    if (j < DIV_STG - 1) begin : g_keep
      logic [RW-1:0] rem_nxt;
      assign rem_nxt = fit ? rem_in - shf : rem_in;
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= rem_nxt;
          dvs_r[j] <= dvs_in;
        end
      end
    end
  end

  assign quo = quo_r[DIV_STG-1];

endmodule

>>> src/segment_segment_squared_distance_unit.sv
`timescale 1ns / 1ps
// Squared closest distance between two 2D segments, one pair per transfer.
//
// Input channel (in_valid / in_stall): first segment start and end, second
// segment start and end, signed Q16.16 coordinates (low COORD_W bits used).
// Result channel (out_valid / out_stall): out_squared_distance, unsigned
// Q35.16, saturating at all ones.
//
// A new pair may be taken every cycle while in_stall is low; the 17-stage
// parameter divider (one quotient bit per stage) and the two-stage wide
// multipliers set the depth.
//
// Every stage carries a valid bit. A stage loads whenever it is empty or the
// stages after it can move, so bubbles close up while out_stall is high and
// in_stall rises only when every stage holds an item. The result register
// holds its item for as long as out_stall is high.
//
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// not reset.
module segment_segment_squared_distance_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_first_start_x,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_first_start_y,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_first_end_x,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_first_end_y,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_second_start_x,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_second_start_y,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_second_end_x,
  input  logic signed [ssd_pkg::IN_W-1:0]   in_second_end_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [ssd_pkg::OUT_W-1:0]  out_squared_distance
);
  import ssd_pkg::*;

  // ---------------------------------------------------------------- control
  logic [NSTG:1] v_r, v_nxt;
  logic [NSTG:1] en;

  // stage i may load when the output can drain or it or some later stage is empty
  for (genvar i = 1; i <= NSTG; i++) begin : g_en
    assign en[i] = !out_stall || !(&v_r[NSTG:i]);
  end

  always_comb begin
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int i = 2; i <= NSTG; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NSTG];

  // ------------------------------------------------------- stage 1: deltas
  logic signed [COORD_W-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
  geo_t                      geo_nxt;
  geo_t                      geo_r [1:ST_SCL];

  assign p1x = in_first_start_x[COORD_W-1:0];
  assign p1y = in_first_start_y[COORD_W-1:0];
  assign p2x = in_first_end_x[COORD_W-1:0];
  assign p2y = in_first_end_y[COORD_W-1:0];
  assign q1x = in_second_start_x[COORD_W-1:0];
  assign q1y = in_second_start_y[COORD_W-1:0];
  assign q2x = in_second_end_x[COORD_W-1:0];
  assign q2y = in_second_end_y[COORD_W-1:0];

  // u = P.end - P.start, v = Q.end - Q.start, w = P.start - Q.start
  always_comb begin
    geo_nxt.ux = DW'(p2x) - DW'(p1x);
    geo_nxt.uy = DW'(p2y) - DW'(p1y);
    geo_nxt.vx = DW'(q2x) - DW'(q1x);
    geo_nxt.vy = DW'(q2y) - DW'(q1y);
    geo_nxt.wx = DW'(p1x) - DW'(q1x);
    geo_nxt.wy = DW'(p1y) - DW'(q1y);
  end

  // deltas ride along until the closest-point stage
  for (genvar i = ST_DIFF; i <= ST_SCL; i++) begin : g_geo
    if (i == ST_DIFF) begin : g_load
      always_ff @(posedge clk) begin
        if (en[i]) begin
          geo_r[i] <= geo_nxt;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[i]) begin
          geo_r[i] <= geo_r[i-1];
        end
      end
    end
  end

  // ----------------------------------------------- stage 2: delta products
  geo_t                    g1;
  logic signed [PRODW-1:0] pr_nxt [10];
  logic signed [PRODW-1:0] pr_r   [10];

  assign g1 = geo_r[ST_DIFF];
  assign pr_nxt[0] = g1.ux * g1.ux;
  assign pr_nxt[1] = g1.uy * g1.uy;
  assign pr_nxt[2] = g1.ux * g1.vx;
  assign pr_nxt[3] = g1.uy * g1.vy;
  assign pr_nxt[4] = g1.vx * g1.vx;
  assign pr_nxt[5] = g1.vy * g1.vy;
  assign pr_nxt[6] = g1.ux * g1.wx;
  assign pr_nxt[7] = g1.uy * g1.wy;
  assign pr_nxt[8] = g1.vx * g1.wx;
  assign pr_nxt[9] = g1.vy * g1.wy;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      pr_r <= pr_nxt;
    end
  end

  // ------------------------------------------------- stage 3: dot products
  dot_t dot_nxt;
  dot_t dot_r [ST_DOT:ST_DET];

  always_comb begin
    dot_nxt.a = DOTW'(pr_r[0]) + DOTW'(pr_r[1]);   // u.u
    dot_nxt.b = DOTW'(pr_r[2]) + DOTW'(pr_r[3]);   // u.v
    dot_nxt.c = DOTW'(pr_r[4]) + DOTW'(pr_r[5]);   // v.v
    dot_nxt.d = DOTW'(pr_r[6]) + DOTW'(pr_r[7]);   // u.w
    dot_nxt.e = DOTW'(pr_r[8]) + DOTW'(pr_r[9]);   // v.w
  end

  for (genvar i = ST_DOT; i <= ST_DET; i++) begin : g_dot
    if (i == ST_DOT) begin : g_load
      always_ff @(posedge clk) begin
        if (en[i]) begin
          dot_r[i] <= dot_nxt;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[i]) begin
          dot_r[i] <= dot_r[i-1];
        end
      end
    end
  end

  // ----------------------------------- stages 4-5: cross products of dots
  dot_t                 d3;
  logic signed [PW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  assign d3 = dot_r[ST_DOT];

  ssd_mul u_mul_ac (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.a)), .b(MW'(d3.c)), .p(p_ac));
  ssd_mul u_mul_bb (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.b)), .b(MW'(d3.b)), .p(p_bb));
  ssd_mul u_mul_be (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.b)), .b(MW'(d3.e)), .p(p_be));
  ssd_mul u_mul_cd (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.c)), .b(MW'(d3.d)), .p(p_cd));
  ssd_mul u_mul_ae (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.a)), .b(MW'(d3.e)), .p(p_ae));
  ssd_mul u_mul_bd (.clk, .en(en[ST_MUL+1:ST_MUL]), .a(MW'(d3.b)), .b(MW'(d3.d)), .p(p_bd));

  // ------------------------------- stage 6: determinant and raw numerators
  logic signed [NW-1:0] det_nxt, sn0_nxt, tn0_nxt;
  logic signed [NW-1:0] det_r, sn0_r, tn0_r;

  assign det_nxt = NW'(p_ac) - NW'(p_bb);
  assign sn0_nxt = NW'(p_be) - NW'(p_cd);
  assign tn0_nxt = NW'(p_ae) - NW'(p_bd);

  always_ff @(posedge clk) begin
    if (en[ST_DET]) begin
      det_r <= det_nxt;
      sn0_r <= sn0_nxt;
      tn0_r <= tn0_nxt;
    end
  end

  // ------------------------------------- stage 7: clamp first parameter
  // Parallel or degenerate pairs (det not positive) pin s to the start.
  // The -d and b-d tests for the second pass are settled here as well.
  dot_t                   dk;
  frac_t                  cl1_nxt, cl1_r;
  logic signed [MDW-1:0]  md_nxt, mdb_nxt, md_r, mdb_r;
  logic signed [DOTW-1:0] a7_r;
  logic                   md_neg_r, md_gt_r, mdb_neg_r, mdb_gt_r;

  assign dk      = dot_r[ST_DET];
  assign md_nxt  = MDW'(0) - MDW'(dk.d);
  assign mdb_nxt = MDW'(dk.b) - MDW'(dk.d);

  always_comb begin
    cl1_nxt.sn = sn0_r;
    cl1_nxt.sd = det_r;
    cl1_nxt.tn = tn0_r;
    cl1_nxt.td = det_r;
    if (det_r <= 0) begin
      cl1_nxt.sn = '0;
      cl1_nxt.sd = NW'(1);
      cl1_nxt.tn = NW'(dk.e);
      cl1_nxt.td = NW'(dk.c);
    end else if (sn0_r < 0) begin
      cl1_nxt.sn = '0;
      cl1_nxt.tn = NW'(dk.e);
      cl1_nxt.td = NW'(dk.c);
    end else if (sn0_r > det_r) begin
      cl1_nxt.sn = det_r;
      cl1_nxt.tn = NW'(dk.e) + NW'(dk.b);
      cl1_nxt.td = NW'(dk.c);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CL1]) begin
      cl1_r     <= cl1_nxt;
      a7_r      <= dk.a;
      md_r      <= md_nxt;
      mdb_r     <= mdb_nxt;
      md_neg_r  <= md_nxt < 0;
      md_gt_r   <= md_nxt > MDW'(dk.a);
      mdb_neg_r <= mdb_nxt < 0;
      mdb_gt_r  <= mdb_nxt > MDW'(dk.a);
    end
  end

  // ------------------------------ stage 8: clamp second, re-clamp first
  frac_t cl2_nxt, cl2_r;

  always_comb begin
    cl2_nxt = cl1_r;
    if (cl1_r.tn < 0) begin
      cl2_nxt.tn = '0;
      if (md_neg_r) begin
        cl2_nxt.sn = '0;
      end else if (md_gt_r) begin
        cl2_nxt.sn = cl1_r.sd;
      end else begin
        cl2_nxt.sn = NW'(md_r);
        cl2_nxt.sd = NW'(a7_r);
      end
    end else if (cl1_r.tn > cl1_r.td) begin
      cl2_nxt.tn = cl1_r.td;
      if (mdb_neg_r) begin
        cl2_nxt.sn = '0;
      end else if (mdb_gt_r) begin
        cl2_nxt.sn = cl1_r.sd;
      end else begin
        cl2_nxt.sn = NW'(mdb_r);
        cl2_nxt.sd = NW'(a7_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CL2]) begin
      cl2_r <= cl2_nxt;
    end
  end

  // ---------------------------------- stages 9-25: parameter quotients
  logic [QW-1:0] sc, tc;

  ssd_div u_div_s (
    .clk,
    .en  (en[ST_DIVN:ST_DIV0]),
    .num (cl2_r.sn),
    .den (cl2_r.sd),
    .quo (sc)
  );

  ssd_div u_div_t (
    .clk,
    .en  (en[ST_DIVN:ST_DIV0]),
    .num (cl2_r.tn),
    .den (cl2_r.td),
    .quo (tc)
  );

  // ----------------------------------- stage 26: scale segment directions
  geo_t                  gq;
  logic signed [DXW-1:0] sux_nxt, suy_nxt, svx_nxt, svy_nxt;
  logic signed [DXW-1:0] sux_r, suy_r, svx_r, svy_r;

  assign gq      = geo_r[ST_DIVN];
  assign sux_nxt = gq.ux * $signed({1'b0, sc});
  assign suy_nxt = gq.uy * $signed({1'b0, sc});
  assign svx_nxt = gq.vx * $signed({1'b0, tc});
  assign svy_nxt = gq.vy * $signed({1'b0, tc});

  always_ff @(posedge clk) begin
    if (en[ST_SCL]) begin
      sux_r <= sux_nxt;
      suy_r <= suy_nxt;
      svx_r <= svx_nxt;
      svy_r <= svy_nxt;
    end
  end

  // ------------------------- stage 27: closest-point difference w + us - vt
  geo_t                  gw;
  logic signed [DXW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;

  assign gw     = geo_r[ST_SCL];
  assign dx_nxt = (DXW'(gw.wx) <<< FRAC_W) + sux_r - svx_r;
  assign dy_nxt = (DXW'(gw.wy) <<< FRAC_W) + suy_r - svy_r;

  always_ff @(posedge clk) begin
    if (en[ST_DX]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // ----------------------------------------------- stages 28-29: squares
  logic signed [PW-1:0] p_xx, p_yy;

  ssd_mul u_mul_xx (.clk, .en(en[ST_SQ+1:ST_SQ]), .a(MW'(dx_r)), .b(MW'(dx_r)), .p(p_xx));
  ssd_mul u_mul_yy (.clk, .en(en[ST_SQ+1:ST_SQ]), .a(MW'(dy_r)), .b(MW'(dy_r)), .p(p_yy));

  // -------------------------------- stage 30: sum, truncate and saturate
  logic signed [NW-1:0]  n_sum;
  logic signed [NXW-1:0] n_ext;
  logic                  sat;
  logic [OUT_W-1:0]      out_nxt, out_r;

  assign n_sum   = NW'(p_xx) + NW'(p_yy);   // units of 2^-64, never negative
  assign n_ext   = NXW'(n_sum);
  assign sat     = |n_ext[NXW-1:SATW];
  assign out_nxt = sat ? '1 : n_ext[SATW-1:DROP_W];

  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      out_r <= out_nxt;
    end
  end

  assign out_squared_distance = out_r;

  // ------------------------------------------------------------ assertions
  // u.u and v.v are never negative
  a_dot_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_DOT] |-> (dot_r[ST_DOT].a >= 0) && (dot_r[ST_DOT].c >= 0))
    else $error("negative squared length");

  // Cauchy-Schwarz: a*c - b*b is never negative
  a_det_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_DET] |-> !det_r[NW-1])
    else $error("negative determinant");

  // after clamping both fractions lie in [0, 1]
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_CL2] |-> (cl2_r.sn >= 0) && (cl2_r.sn <= cl2_r.sd) &&
                    (cl2_r.tn >= 0) && (cl2_r.tn <= cl2_r.td))
    else $error("segment parameter out of range");

  // quotients never exceed one
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_DIVN] |-> (sc <= QW'(QONE)) && (tc <= QW'(QONE)))
    else $error("parameter quotient above one");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the segment pair squared distance unit.
// Pairs go in through the in_ channel, and each one is scored against an
// in-bench closest-point predictor built on 192-bit exact arithmetic.
module testbench;
  import ssd_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef logic [IN_W-1:0] pair_t [8];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_first_start_x = '0, in_first_start_y = '0;
  logic signed [IN_W-1:0] in_first_end_x = '0, in_first_end_y = '0;
  logic signed [IN_W-1:0] in_second_start_x = '0, in_second_start_y = '0;
  logic signed [IN_W-1:0] in_second_end_x = '0, in_second_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_squared_distance;

  // Per-phase idling, in percent
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  logic [OUT_W-1:0] dist_q[$];

  segment_segment_squared_distance_unit uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // Low COORD_W bits of a field as two's complement
  function automatic longint to_coord(input logic [IN_W-1:0] raw);
    logic [63:0] v;
    v = 64'(raw) & ((64'd1 << COORD_W) - 64'd1);
    if (v[COORD_W-1]) return longint'(v) - (longint'(1) << COORD_W);
    return longint'(v);
  endfunction

  // trunc(num * 2^16 / den), capped at 131071, zero for non-positive operands
  function automatic longint param_quot(input wide_t num, input wide_t den);
    wide_t q;
    if (den <= 0 || num <= 0) return 0;
    q = (num <<< FRAC_W) / den;
    if (q > 131071) q = 131071;
    return longint'(q);
  endfunction

  function automatic logic [OUT_W-1:0] closest_sq_dist(input pair_t p);
    longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    longint sc, tc;
    wide_t ux, uy, vx, vy, wx, wy, a, b, c, d, e, det;
    wide_t sn, sd, tn, td, md, mdb, dx, dy, n;
    p1x = to_coord(p[0]); p1y = to_coord(p[1]);
    p2x = to_coord(p[2]); p2y = to_coord(p[3]);
    q1x = to_coord(p[4]); q1y = to_coord(p[5]);
    q2x = to_coord(p[6]); q2y = to_coord(p[7]);
    ux = p2x - p1x; uy = p2y - p1y;
    vx = q2x - q1x; vy = q2y - q1y;
    wx = p1x - q1x; wy = p1y - q1y;
    a = ux * ux + uy * uy;
    b = ux * vx + uy * vy;
    c = vx * vx + vy * vy;
    d = ux * wx + uy * wy;
    e = vx * wx + vy * wy;
    det = a * c - b * b;
    sd = det; td = det; md = -d;
    if (det <= 0) begin
      // parallel or degenerate: pin the first parameter at zero
      sn = 0; sd = 1; tn = e; td = c;
    end else begin
      sn = b * e - c * d;
      tn = a * e - b * d;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
    end
    if (tn < 0) begin
      tn = 0;
      if (md < 0) sn = 0;
      else if (md > a) sn = sd;
      else begin
        sn = md; sd = a;
      end
    end else if (tn > td) begin
      mdb = md + b;
      tn = td;
      if (mdb < 0) sn = 0;
      else if (mdb > a) sn = sd;
      else begin
        sn = mdb; sd = a;
      end
    end
    sc = param_quot(sn, sd);
    tc = param_quot(tn, td);
    dx = (wx <<< FRAC_W) + ux * sc - vx * tc;
    dy = (wy <<< FRAC_W) + uy * sc - vy * tc;
    n = dx * dx + dy * dy;
    if (n >= (wide_t'(1) <<< 99)) return '1;
    return n[98:48];
  endfunction

  // One pair, held until the unit takes it
  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_start_x <= p[0]; in_first_start_y <= p[1];
    in_first_end_x <= p[2]; in_first_end_y <= p[3];
    in_second_start_x <= p[4]; in_second_start_y <= p[5];
    in_second_end_x <= p[6]; in_second_end_y <= p[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dist_q.push_back(closest_sq_dist(p));
    pairs_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Result side: random stall and scoring of each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $error("unexpected result squared_distance=%0h", out_squared_distance);
          errors++;
        end else begin
          if (out_squared_distance !== dist_q[0]) begin
            $error("squared_distance expected %0h actual %0h",
                   dist_q[0], out_squared_distance);
            errors++;
          end
          void'(dist_q.pop_front());
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  function automatic logic [31:0] any_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {{12{1'($urandom_range(1))}}, 20'($urandom())};   // small magnitude
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
    endcase
  endfunction

  // General pairs half the time, with parallel, collinear and point cases mixed in
  function automatic pair_t random_pair();
    pair_t p;
    logic [31:0] ox, oy;
    int k;
    for (int i = 0; i < 8; i++) p[i] = any_word();
    case ($urandom_range(5))
      0: begin   // second segment a shifted copy of the first
        ox = any_word() >>> 2; oy = any_word() >>> 2;
        p[4] = p[0] + ox; p[5] = p[1] + oy;
        p[6] = p[2] + ox; p[7] = p[3] + oy;
      end
      1: begin   // collinear, scaled direction
        k = $urandom_range(3) + 1;
        p[2] = p[0] + ((p[2] - p[0]) >>> 3); p[3] = p[1] + ((p[3] - p[1]) >>> 3);
        p[4] = p[0] + k * (p[2] - p[0]); p[5] = p[1] + k * (p[3] - p[1]);
        p[6] = p[0] - (p[2] - p[0]); p[7] = p[1] - (p[3] - p[1]);
      end
      2: begin   // degenerate segment
        if ($urandom_range(1)) begin p[2] = p[0]; p[3] = p[1]; end
        else begin p[6] = p[4]; p[7] = p[5]; end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    logic [31:0] mx, mn;
    mx = 32'h7fffffff; mn = 32'h80000000;
    p = '{default: 32'h0}; send_pair(p);                 // all points at origin
    p = '{mn, mn, mx, mx, mx, mn, mn, mx}; send_pair(p); // crossing diagonals
    p = '{mn, mn, mn, mn, mx, mx, mx, mx}; send_pair(p); // farthest points
    p = '{mx, mx, mn, mn, mx, mx, mn, mn}; send_pair(p); // identical segments
    p = '{mn, 0, mx, 0, mn, mx, mx, mx}; send_pair(p);   // parallel, far apart
    p = '{0, 0, 32'h10000, 0, 32'h30000, 0, 32'h40000, 0}; send_pair(p); // collinear gap
    p = '{0, 0, 32'h10000, 0, 32'h8000, 32'h10000, 32'h8000, 32'h20000};
    send_pair(p);                                        // interior to segment
    p = '{0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0}; send_pair(p);
    p = '{0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000}; send_pair(p);
    p = '{0, 0, 32'h20000, 0, 32'hfffe0000, 32'h10000, 32'hffff0000, 32'h20000};
    send_pair(p);                                        // first parameter clamps low
    p = '{0, 0, 32'h20000, 0, 32'h40000, 32'h10000, 32'h50000, 32'h20000};
    send_pair(p);                                        // first parameter clamps high, second low
    p = '{32'h1, 32'h1, 32'hffffffff, 32'hffffffff, 0, 32'h2, 32'h2, 0}; send_pair(p);
    p = '{32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
          32'h33333333, 32'hcccccccc, 32'hcccccccc, 32'h33333333}; send_pair(p);
    p = '{mx, 0, mx, 0, mn, 0, mn, 0}; send_pair(p);     // two points, x extremes
    p = '{0, mn, 0, mx, 32'h10000, mn, 32'h10000, mx}; send_pair(p);
    wait_drained();
  endtask

  task automatic test_random(input int sidle, input int rstall, input int count);
    send_idle = sidle;
    recv_stall = rstall;
    for (int i = 0; i < count; i++) send_pair(random_pair());
    wait_drained();
  endtask

  // Sender holds off until the pipe is empty, then bursts again
  task automatic test_hold_off();
    send_idle = 0;
    recv_stall = 30;
    for (int i = 0; i < 40; i++) send_pair(random_pair());
    wait_drained();
    for (int i = 0; i < 40; i++) send_pair(random_pair());
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 230);
    test_random(75, 0, 200);
    test_random(0, 75, 200);
    test_random(11, 11, 240);
    test_hold_off();
    $display("Covered %0d segment pairs (%0d results) over no-idle, sender-idle,",
             pairs_sent, results_seen);
    $display("receiver-stall and mixed phases, with parallel and degenerate cases.");
    if (errors == 0 && dist_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> files.f
src/ssd_pkg.sv
src/ssd_mul.sv
src/ssd_div.sv
src/segment_segment_squared_distance_unit.sv
test/testbench.sv
